/* rtl/core/wsa_pkg.sv */
// shared widths and codes of the windowed sample averager
`default_nettype none
package wsa_pkg;
  localparam int SAMPLE_W = 16;
  localparam int CM_W = 13;
  localparam int CNT_W = 7;
  localparam int SUM_W = 23;
  localparam int WIN_W = 17;
  localparam int NUM_W = 24;
  localparam int DEN_W = 12;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_CM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_CM = 2'd1;
  localparam logic [CM_W-1:0] UPPER_CM_RESET = 13'd6553;
endpackage
`default_nettype wire

/* rtl/core/wsa_if.sv */
// request channels of the windowed sample averager
`default_nettype none
interface wsa_in_if;
  logic valid;
  logic ready;
  logic [wsa_pkg::SAMPLE_W-1:0] sample_mm;
  logic last;
  modport source (output valid, output sample_mm, output last, input ready);
  modport sink (input valid, input sample_mm, input last, output ready);
endinterface

interface wsa_out_if;
  logic valid;
  logic ready;
  logic [wsa_pkg::CM_W-1:0] mean_cm;
  logic [wsa_pkg::CNT_W-1:0] good_count;
  logic none_good;
  logic in_range;
  logic overflow;
  modport source (output valid, output mean_cm, output good_count, output none_good,
                  output in_range, output overflow, input ready);
  modport sink (input valid, input mean_cm, input good_count, input none_good,
                input in_range, input overflow, output ready);
endinterface

interface wsa_cfg_if;
  logic valid;
  logic ready;
  logic [wsa_pkg::CFG_IDX_W-1:0] index;
  logic [wsa_pkg::CM_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/windowed_sample_averager.sv */
// Averages millimetre distance samples that fall strictly inside the window
// (lower_cm*10, upper_cm*10) and, on the sample flagged last, returns the mean in
// centimetres rounded half up, the accepted count and range/overflow flags. A sample
// without last is added to the run and the block is ready again the next cycle.
// A last sample is followed by a step that forms numerator and divisor, the
// bit-per-cycle restoring divider, and a step that loads the output register once
// the output is free. The next run may start while a result waits on the output.
// Samples past MAX_SAMPLES in a run are dropped and flagged.
`default_nettype none
module windowed_sample_averager #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  wsa_cfg_if.sink   cfg_ch,
  wsa_in_if.sink    in_ch,
  wsa_out_if.source out_ch
);
  import wsa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [CM_W-1:0] lower_r, upper_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] seen_r, seen_nxt;
  logic ovf_r, ovf_nxt;

  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] res_cnt_r;
  logic res_none_r, res_ovf_r;

  logic out_valid_r;
  logic [CM_W-1:0] out_mean_r;
  logic [CNT_W-1:0] out_cnt_r;
  logic out_none_r, out_rng_r, out_ovf_r;

  logic fire, room, in_win, load_out;
  logic [WIN_W-1:0] lower_mm, upper_mm, sample_ext;
  logic [DEN_W:0] rem_sh, rem_diff;
  logic rem_ge;
  logic [CM_W-1:0] mean;
  logic rng;

  // configuration
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= '0;
      upper_r <= UPPER_CM_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == CFG_LOWER_CM) lower_r <= cfg_ch.data;
      if (cfg_ch.index == CFG_UPPER_CM) upper_r <= cfg_ch.data;
    end
  end

  // window bounds in millimetres, times ten as shift-add
  assign lower_mm = WIN_W'({lower_r, 3'b000}) + WIN_W'({lower_r, 1'b0});
  assign upper_mm = WIN_W'({upper_r, 3'b000}) + WIN_W'({upper_r, 1'b0});
  assign sample_ext = WIN_W'(in_ch.sample_mm);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign fire = in_ch.valid && in_ch.ready;
  assign room = (seen_r < CNT_W'(MAX_SAMPLES));
  assign in_win = (sample_ext > lower_mm) && (sample_ext < upper_mm);

  // divider step
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_r});
  assign rem_diff = rem_sh - {1'b0, den_r};

  assign mean = res_none_r ? '0 : num_r[CM_W-1:0];
  assign rng = !res_none_r && (mean >= lower_r) && (mean <= upper_r);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    sum_nxt = sum_r;
    acc_nxt = acc_r;
    seen_nxt = seen_r;
    ovf_nxt = ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (fire) begin
          if (room) begin
            seen_nxt = seen_r + 1'b1;
            if (in_win) begin
              sum_nxt = sum_r + SUM_W'(in_ch.sample_mm);
              acc_nxt = acc_r + 1'b1;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last) state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        // run totals are latched into the divider here, so clear the run
        sum_nxt = '0;
        acc_nxt = '0;
        seen_nxt = '0;
        ovf_nxt = 1'b0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sum_r <= '0;
      acc_r <= '0;
      seen_r <= '0;
      ovf_r <= 1'b0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r <= sum_nxt;
      acc_r <= acc_nxt;
      seen_r <= seen_nxt;
      ovf_r <= ovf_nxt;
      if (state_r == ST_PREP) cnt_r <= '0;
      else if (state_r == ST_DIV) cnt_r <= cnt_r + 1'b1;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // numerator 2*sum + 10*n, divisor 20*n, quotient shifts into num_r
  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      num_r <= NUM_W'({sum_r, 1'b0}) + NUM_W'({acc_r, 3'b000}) + NUM_W'({acc_r, 1'b0});
      den_r <= DEN_W'({acc_r, 4'b0000}) + DEN_W'({acc_r, 2'b00});
      rem_r <= '0;
      res_cnt_r <= acc_r;
      res_none_r <= (acc_r == '0);
      res_ovf_r <= ovf_r;
    end else if (state_r == ST_DIV) begin
      rem_r <= rem_ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      num_r <= {num_r[NUM_W-2:0], rem_ge};
    end
    if (load_out) begin
      out_mean_r <= mean;
      out_cnt_r <= res_cnt_r;
      out_none_r <= res_none_r;
      out_rng_r <= rng;
      out_ovf_r <= res_ovf_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.mean_cm = out_mean_r;
  assign out_ch.good_count = out_cnt_r;
  assign out_ch.none_good = out_none_r;
  assign out_ch.in_range = out_rng_r;
  assign out_ch.overflow = out_ovf_r;

  a_acc_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= seen_r)
    else $error("accepted count above seen count");

  a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r <= CNT_W'(MAX_SAMPLES))
    else $error("seen count past window size");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) |=> (state_r == ST_DONE))
    else $error("divider did not finish after its last step");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_none_r |-> (out_mean_r == '0) && (out_cnt_r == '0) && !out_rng_r)
    else $error("empty run reported a mean, count or range");
endmodule
`default_nettype wire

/* tb/tb_windowed_sample_averager.sv */
// testbench of the windowed sample averager: directed table, then random runs against a predictor
module tb_windowed_sample_averager;
  import wsa_pkg::*;

  localparam int MAX_SAMPLES = 64;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS = 100;
  localparam int RANDOM_PHASES = 9;
  // indexes past the two registers, written only to see them ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [CM_W-1:0]  mean_cm;
    logic [CNT_W-1:0] good_count;
    logic             none_good;
    logic             in_range;
    logic             overflow;
  } mean_rec_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [SAMPLE_W-1:0]    value;
    bit                     last;
    int                     reps;
    bit                     typed;
    mean_rec_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  wsa_cfg_if cfg_bus ();
  wsa_in_if  in_bus ();
  wsa_out_if out_bus ();

  windowed_sample_averager #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  logic [CM_W-1:0]  lower_thr = '0;
  logic [CM_W-1:0]  upper_thr = UPPER_CM_RESET;
  logic [SUM_W-1:0] run_sum_mm = '0;
  logic [CNT_W-1:0] run_taken = '0;
  logic [CNT_W-1:0] run_seen = '0;
  logic             run_overflowed = 1'b0;

  mean_rec_t pending_means[$];
  mean_rec_t got_mean, want_mean, folded;

  // typed expectation that travels with the request on the input channel
  bit        row_typed = 1'b0;
  mean_rec_t row_want = '0;

  bit calm = 1'b0;
  int n_fail = 0;
  int n_samples = 0;
  int n_means = 0;
  int n_ovf_means = 0;
  int n_empty_means = 0;
  int n_reg_writes = 0;
  int n_settings = 1;

  stim_row_t dir_tab[$];

  task automatic note_failure(input string msg);
    n_fail++;
    if (n_fail <= 10) $display("ERROR: %s", msg);
  endtask

  function automatic bit fold_sample(input logic [SAMPLE_W-1:0] s, input bit l,
                                     output mean_rec_t r);
    int unsigned num, den, m;
    r = '0;
    if (run_seen < MAX_SAMPLES) begin
      run_seen = run_seen + 1'b1;
      if (s > lower_thr * 10 && s < upper_thr * 10) begin
        run_sum_mm = run_sum_mm + s;
        run_taken = run_taken + 1'b1;
      end
    end else begin
      run_overflowed = 1'b1;
    end
    if (!l) return 1'b0;
    r.good_count = run_taken;
    r.overflow = run_overflowed;
    r.none_good = (run_taken == 0);
    if (run_taken != 0) begin
      // exact division, rounded half up
      num = 2 * run_sum_mm + 10 * run_taken;
      den = 20 * run_taken;
      m = num / den;
      r.mean_cm = m[CM_W-1:0];
      r.in_range = (m >= lower_thr && m <= upper_thr);
    end
    run_sum_mm = '0;
    run_taken = '0;
    run_seen = '0;
    run_overflowed = 1'b0;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        got_mean = '{out_bus.mean_cm, out_bus.good_count, out_bus.none_good,
                     out_bus.in_range, out_bus.overflow};
        if (pending_means.size() == 0) begin
          note_failure($sformatf("average with none pending: mean %0d count %0d",
                                 got_mean.mean_cm, got_mean.good_count));
        end else begin
          want_mean = pending_means.pop_front();
          if (got_mean.mean_cm !== want_mean.mean_cm ||
              got_mean.good_count !== want_mean.good_count ||
              got_mean.none_good !== want_mean.none_good ||
              got_mean.in_range !== want_mean.in_range ||
              got_mean.overflow !== want_mean.overflow) begin
            note_failure($sformatf(
              "avg %0d: want mean %0d cnt %0d none %0b in %0b ovf %0b, got %0d %0d %0b %0b %0b",
              n_means, want_mean.mean_cm, want_mean.good_count, want_mean.none_good,
              want_mean.in_range, want_mean.overflow, got_mean.mean_cm, got_mean.good_count,
              got_mean.none_good, got_mean.in_range, got_mean.overflow));
          end
          if (want_mean.overflow) n_ovf_means++;
          if (want_mean.none_good) n_empty_means++;
        end
        n_means++;
      end
      if (cfg_bus.valid && cfg_bus.ready) begin
        n_reg_writes++;
        if (cfg_bus.index == CFG_LOWER_CM) lower_thr = cfg_bus.data;
        else if (cfg_bus.index == CFG_UPPER_CM) upper_thr = cfg_bus.data;
      end
      if (in_bus.valid && in_bus.ready) begin
        n_samples++;
        if (fold_sample(in_bus.sample_mm, in_bus.last, folded))
          pending_means.push_back(row_typed ? row_want : folded);
      end
    end
  end

  // result side: bursts of ready, broken by short and now and then long stalls
  initial begin
    int burst, stall;
    out_bus.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_bus.ready = 1'b1;
      repeat (burst) @(negedge clk);
      stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
      if (stall > 0) begin
        out_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input int unsigned lo,
                                                      input int unsigned hi);
    int unsigned lo_mm, hi_mm, top, v;
    lo_mm = lo * 10;
    hi_mm = hi * 10;
    top = (hi_mm == 0) ? 0 : hi_mm - 1;
    if (top > 65535) top = 65535;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 65535);
      1: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 65535;
          2: v = lo_mm;
          3: v = lo_mm + 1;
          4: v = top;
          default: v = hi_mm;
        endcase
      end
      default: begin
        if (top > lo_mm) v = $urandom_range(lo_mm + 1, top);
        else v = $urandom_range(0, 65535);
      end
    endcase
    if (v > 65535) v = 65535;
    return v[SAMPLE_W-1:0];
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit l, input bit typed,
                             input mean_rec_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.sample_mm = s;
    in_bus.last = l;
    row_typed = typed;
    row_want = w;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (pending_means.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CM_W-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data = data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic mean_rec_t mean_of(input int m, input int n, input bit none,
                                        input bit inr, input bit ovf);
    mean_rec_t r;
    r.mean_cm = CM_W'(m);
    r.good_count = CNT_W'(n);
    r.none_good = none;
    r.in_range = inr;
    r.overflow = ovf;
    return r;
  endfunction

  function automatic stim_row_t item_row(input int v, input bit l, input int reps,
                                         input bit typed, input mean_rec_t w);
    stim_row_t r;
    r.kind = ROW_ITEM;
    r.idx = CFG_LOWER_CM;
    r.value = SAMPLE_W'(v);
    r.last = l;
    r.reps = reps;
    r.typed = typed;
    r.want = w;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    stim_row_t r;
    r = item_row(data, 1'b0, 1, 1'b0, '0);
    r.kind = ROW_CFG;
    r.idx = idx;
    return r;
  endfunction

  initial begin
    int unsigned lo, hi, len, phase_cnt;
    in_bus.valid = 1'b0;
    in_bus.sample_mm = '0;
    in_bus.last = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_LOWER_CM;
    cfg_bus.data = '0;

    // thresholds at reset: 0 and 6553
    dir_tab.push_back(item_row(0, 1, 1, 1, mean_of(0, 0, 1, 0, 0)));       // zero is not above lower
    dir_tab.push_back(item_row(65535, 1, 1, 1, mean_of(0, 0, 1, 0, 0)));
    dir_tab.push_back(item_row(65529, 1, 1, 1, mean_of(6553, 1, 0, 1, 0)));
    dir_tab.push_back(item_row(65530, 1, 1, 1, mean_of(0, 0, 1, 0, 0)));   // equal to upper bound
    dir_tab.push_back(item_row(1, 1, 1, 1, mean_of(0, 1, 0, 1, 0)));
    dir_tab.push_back(item_row(15, 1, 1, 1, mean_of(2, 1, 0, 1, 0)));      // half rounds up
    dir_tab.push_back(item_row(14, 1, 1, 1, mean_of(1, 1, 0, 1, 0)));
    // full window, then one sample too many
    dir_tab.push_back(item_row(1000, 0, 64, 0, '0));
    dir_tab.push_back(item_row(1000, 1, 1, 1, mean_of(100, 64, 0, 1, 1)));
    // exactly full, no overflow
    dir_tab.push_back(item_row(2000, 0, 63, 0, '0));
    dir_tab.push_back(item_row(4000, 1, 1, 0, '0));
    dir_tab.push_back(item_row(12345, 0, 1, 0, '0));
    dir_tab.push_back(item_row(0, 0, 1, 0, '0));
    dir_tab.push_back(item_row(777, 1, 1, 0, '0));
    // lower above upper, plus writes to unused indexes
    dir_tab.push_back(cfg_row(CFG_LOWER_CM, 500));
    dir_tab.push_back(cfg_row(CFG_UPPER_CM, 100));
    dir_tab.push_back(cfg_row(CFG_SPARE_2, 8191));
    dir_tab.push_back(cfg_row(CFG_SPARE_3, 0));
    dir_tab.push_back(item_row(3000, 0, 1, 0, '0));
    dir_tab.push_back(item_row(6000, 1, 1, 1, mean_of(0, 0, 1, 0, 0)));
    // widest upper threshold lets the top sample through
    dir_tab.push_back(cfg_row(CFG_LOWER_CM, 0));
    dir_tab.push_back(cfg_row(CFG_UPPER_CM, 8191));
    dir_tab.push_back(item_row(65535, 1, 1, 1, mean_of(6554, 1, 0, 1, 0)));
    dir_tab.push_back(item_row(40000, 0, 1, 0, '0));
    dir_tab.push_back(item_row(65535, 1, 1, 0, '0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_tab[k].idx, dir_tab[k].value[CM_W-1:0]);
        n_settings++;
      end else begin
        repeat (dir_tab[k].reps)
          send_sample(dir_tab[k].value, dir_tab[k].last, dir_tab[k].typed, dir_tab[k].want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin lo = 0;    hi = 0;    end
        1: begin lo = 6553; hi = 6553; end
        2: begin lo = 6553; hi = 0;    end
        3: begin lo = 0;    hi = 8191; end
        4: begin lo = 0;    hi = 6553; end
        5: begin lo = $urandom_range(0, 8191); hi = $urandom_range(0, 8191); end
        default: begin
          lo = $urandom_range(0, 4000);
          hi = lo + $urandom_range(1, 2500);
          if (hi > 6553) hi = 6553;
        end
      endcase
      wait_idle();
      if ($urandom_range(0, 1)) begin
        write_reg(CFG_LOWER_CM, CM_W'(lo));
        write_reg(CFG_UPPER_CM, CM_W'(hi));
      end else begin
        write_reg(CFG_UPPER_CM, CM_W'(hi));
        write_reg(CFG_LOWER_CM, CM_W'(lo));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3,
                  CM_W'($urandom_range(0, 8191)));
      n_settings++;
      calm = ($urandom_range(0, 2) == 0);
      phase_cnt = 0;
      while (phase_cnt < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          8: len = $urandom_range(60, 70);
          9: len = $urandom_range(13, 40);
          default: len = $urandom_range(1, 12);
        endcase
        // now and then the sender holds off until every average is back
        if ($urandom_range(0, 19) == 0) wait_idle();
        for (int j = 0; j < len; j++)
          send_sample(pick_sample(lo, hi), j == len - 1, 1'b0, '0);
        phase_cnt += len;
      end
    end

    in_bus.valid = 1'b0;
    for (int w = 0; w < 20000 && pending_means.size() != 0; w++) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_means.size() != 0)
      note_failure($sformatf("%0d averages never arrived", pending_means.size()));

    $display("run: %0d samples, %0d averages checked, %0d with overflow, %0d empty",
             n_samples, n_means, n_ovf_means, n_empty_means);
    $display("run: %0d register writes over %0d threshold settings, %0d failures",
             n_reg_writes, n_settings, n_fail);
    if (n_fail == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
rtl/core/wsa_pkg.sv
rtl/core/wsa_if.sv
rtl/core/windowed_sample_averager.sv
tb/tb_windowed_sample_averager.sv
